FILE: hw/rtl/last_note_priority_key_stack_unit_assert.svh
// Assertion macros for the key stack unit.
`ifndef LAST_NOTE_PRIORITY_KEY_STACK_UNIT_ASSERT_SVH
`define LAST_NOTE_PRIORITY_KEY_STACK_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LNPKS_IMPLIES(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lnpks assertion failed");

// Next-cycle implication.
`define LNPKS_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lnpks assertion failed");

`endif

FILE: hw/rtl/lnpks_pkg.sv
package lnpks_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned NOTE_W          = 14;
  localparam int unsigned SEMI_W          = 7;
  localparam int unsigned OCT_W           = 3;
  localparam int unsigned SEMIS_PER_OCT   = 12;
  localparam int unsigned CENTS_PER_SEMI  = 100;
  localparam int unsigned NOTE_MAX        = 9100;

  localparam logic [OCT_W-1:0] OCT_MAX   = 3'd5;
  localparam logic [OCT_W-1:0] OCT_RESET = 3'd2;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    REQ_PRESS   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_RELEASE,
    OP_CLEAR
  } stk_op_e;

  typedef enum logic [1:0] {
    TS_IDLE,
    TS_BUSY,
    TS_HOLD
  } top_state_e;

  typedef enum logic [2:0] {
    SK_IDLE,
    SK_SEARCH,
    SK_COMPACT,
    SK_PUT,
    SK_TOP_RD,
    SK_TOP
  } stk_state_e;

  typedef struct packed {
    logic              valid;
    stk_op_e           op;
    logic [7:0]        code;
    logic [NOTE_W-1:0] note;
  } stk_cmd_t;

  typedef struct packed {
    logic              done;
    logic              nonempty;
    logic [NOTE_W-1:0] note;
  } stk_rsp_t;

  typedef struct packed {
    logic       hit;
    logic       upper;
    logic [4:0] idx;
  } key_hit_t;

  function automatic key_hit_t key_lookup(logic [7:0] ch);
    key_hit_t r;
    case (ch)
      "z":     r = '{1'b1, 1'b0, 5'd0};
      "s":     r = '{1'b1, 1'b0, 5'd1};
      "x":     r = '{1'b1, 1'b0, 5'd2};
      "d":     r = '{1'b1, 1'b0, 5'd3};
      "c":     r = '{1'b1, 1'b0, 5'd4};
      "v":     r = '{1'b1, 1'b0, 5'd5};
      "g":     r = '{1'b1, 1'b0, 5'd6};
      "b":     r = '{1'b1, 1'b0, 5'd7};
      "h":     r = '{1'b1, 1'b0, 5'd8};
      "n":     r = '{1'b1, 1'b0, 5'd9};
      "j":     r = '{1'b1, 1'b0, 5'd10};
      "m":     r = '{1'b1, 1'b0, 5'd11};
      ",":     r = '{1'b1, 1'b0, 5'd12};
      "l":     r = '{1'b1, 1'b0, 5'd13};
      ".":     r = '{1'b1, 1'b0, 5'd14};
      ";":     r = '{1'b1, 1'b0, 5'd15};
      "/":     r = '{1'b1, 1'b0, 5'd16};
      "q":     r = '{1'b1, 1'b1, 5'd0};
      "2":     r = '{1'b1, 1'b1, 5'd1};
      "w":     r = '{1'b1, 1'b1, 5'd2};
      "3":     r = '{1'b1, 1'b1, 5'd3};
      "e":     r = '{1'b1, 1'b1, 5'd4};
      "r":     r = '{1'b1, 1'b1, 5'd5};
      "5":     r = '{1'b1, 1'b1, 5'd6};
      "t":     r = '{1'b1, 1'b1, 5'd7};
      "6":     r = '{1'b1, 1'b1, 5'd8};
      "y":     r = '{1'b1, 1'b1, 5'd9};
      "7":     r = '{1'b1, 1'b1, 5'd10};
      "u":     r = '{1'b1, 1'b1, 5'd11};
      "i":     r = '{1'b1, 1'b1, 5'd12};
      "9":     r = '{1'b1, 1'b1, 5'd13};
      "o":     r = '{1'b1, 1'b1, 5'd14};
      "0":     r = '{1'b1, 1'b1, 5'd15};
      "p":     r = '{1'b1, 1'b1, 5'd16};
      "[":     r = '{1'b1, 1'b1, 5'd17};
      "=":     r = '{1'b1, 1'b1, 5'd18};
      "]":     r = '{1'b1, 1'b1, 5'd19};
      default: r = '{1'b0, 1'b0, 5'd0};
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/last_note_priority_key_stack_unit.sv
// An octave change or unmatched key skips the stack; a press with room writes the new top;
//   a full-stack press first shifts out the oldest entry; a release searches, then compacts.
// Throughput: one event at a time; the stack memory's single read and write port walks the
//   entries one per cycle, so the rate follows the number of held keys.
// Reset: stack empty, octave 2, note 0, gate low, no transfer pending; entries are not cleared.
module last_note_priority_key_stack_unit
  import lnpks_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key_code[7:0], key_char[15:8]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // note_cents[13:0], gate[14], zero[15]
);

  top_state_e        state_q, state_d;
  logic [OCT_W-1:0]  octave_q, octave_d;
  logic [NOTE_W-1:0] note_q, note_d;
  logic              gate_q, gate_d;
  logic              m_valid_q, m_valid_d;
  logic [15:0]       m_data_q;

  req_e              req;
  logic [7:0]        key_code;
  logic [7:0]        key_char;
  key_hit_t          lk;
  logic [OCT_W:0]    oct_eff;
  logic [SEMI_W-1:0] semi;
  logic [NOTE_W-1:0] note_new;
  logic              accept;
  logic              is_up;
  logic              is_dn;
  logic              need_stack;
  logic              out_free;
  logic              out_load;
  stk_cmd_t          cmd;
  stk_rsp_t          rsp;

  assign req      = req_e'(s_axis_tuser);
  assign key_code = s_axis_tdata[7:0];
  assign key_char = s_axis_tdata[15:8];
  assign lk       = key_lookup(key_char);
  assign oct_eff  = {1'b0, octave_q} + (OCT_W + 1)'(lk.upper);
  assign semi     = SEMI_W'(lk.idx) + SEMI_W'(oct_eff) * SEMI_W'(SEMIS_PER_OCT);
  assign note_new = NOTE_W'(semi) * NOTE_W'(CENTS_PER_SEMI);
  assign is_up    = (key_char == CHAR_PLUS) && (octave_q < OCT_MAX);
  assign is_dn    = (key_char == CHAR_MINUS) && (octave_q != '0);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    case (req) inside
      REQ_PRESS:              need_stack = !is_up && !is_dn && lk.hit;
      REQ_RELEASE, REQ_CLEAR: need_stack = 1'b1;
      default:                need_stack = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: begin
        if (accept) begin
          state_d = (!need_stack || rsp.done) ? TS_HOLD : TS_BUSY;
        end
      end
      TS_BUSY: begin
        if (rsp.done) begin
          state_d = TS_HOLD;
        end
      end
      TS_HOLD: begin
        if (out_free) begin
          state_d = TS_IDLE;
        end
      end
      default: state_d = TS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == TS_IDLE);
    out_load      = (state_q == TS_HOLD) && out_free;
    cmd.valid     = accept && need_stack;
    cmd.code      = key_code;
    cmd.note      = note_new;
    unique case (req)
      REQ_RELEASE: cmd.op = OP_RELEASE;
      REQ_CLEAR:   cmd.op = OP_CLEAR;
      default:     cmd.op = OP_PUSH;
    endcase
  end

  always_comb begin
    octave_d = octave_q;
    if (accept && (req == REQ_PRESS)) begin
      if (is_up) begin
        octave_d = octave_q + 3'd1;
      end else if (is_dn) begin
        octave_d = octave_q - 3'd1;
      end
    end
    note_d = note_q;
    gate_d = gate_q;
    if (rsp.done) begin
      if (rsp.nonempty) begin
        note_d = rsp.note;
        gate_d = 1'b1;
      end else begin
        gate_d = 1'b0;
      end
    end
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  lnpks_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .rsp_o (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TS_IDLE;
      octave_q  <= OCT_RESET;
      note_q    <= '0;
      gate_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      octave_q  <= octave_d;
      note_q    <= note_d;
      gate_q    <= gate_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {1'b0, gate_q, note_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: hw/rtl/lnpks_stack.sv
module lnpks_stack
  import lnpks_pkg::*;
#(
  parameter int unsigned DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  stk_cmd_t cmd_i,
  output stk_rsp_t rsp_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = CW + 1;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
  localparam logic [EW-1:0] ONE_E   = EW'(1);
  localparam logic [EW-1:0] TWO_E   = EW'(2);

  typedef struct packed {
    logic [7:0]        code;
    logic [NOTE_W-1:0] note;
  } entry_t;

  stk_state_e        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  stk_op_e           op_q, op_d;
  logic [7:0]        code_q, code_d;
  logic [NOTE_W-1:0] ent_note_q, ent_note_d;

  entry_t            mem [DEPTH];
  entry_t            rd_q;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [AW-1:0]     raddr;

  logic [EW-1:0]     cnt_e;
  logic [EW-1:0]     ptr_e;
  logic              full;
  logic              match;
  logic              hit_shift;
  logic              cmp_more;
  logic              ptr_zero;

  assign cnt_e     = EW'(count_q);
  assign ptr_e     = EW'(ptr_q);
  assign full      = (cnt_e == DEPTH_E);
  assign match     = (rd_q.code == code_q);
  assign hit_shift = match && ((ptr_e + ONE_E) < cnt_e);
  assign cmp_more  = (ptr_e + TWO_E) < cnt_e;
  assign ptr_zero  = (ptr_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SK_IDLE: begin
        if (cmd_i.valid) begin
          unique case (cmd_i.op)
            OP_PUSH: begin
              if (full) begin
                state_d = (ONE_E < cnt_e) ? SK_COMPACT : SK_PUT;
              end
            end
            OP_RELEASE: begin
              if (count_q != '0) begin
                state_d = SK_SEARCH;
              end
            end
            default: state_d = SK_IDLE;
          endcase
        end
      end
      SK_SEARCH: begin
        if (match) begin
          if (hit_shift) begin
            state_d = SK_COMPACT;
          end else if (cnt_e == ONE_E) begin
            state_d = SK_IDLE;
          end else begin
            state_d = SK_TOP_RD;
          end
        end else if (ptr_zero) begin
          state_d = SK_TOP_RD;
        end
      end
      SK_COMPACT: begin
        if (!cmp_more) begin
          state_d = (op_q == OP_PUSH) ? SK_PUT : SK_TOP_RD;
        end
      end
      SK_PUT:    state_d = SK_IDLE;
      SK_TOP_RD: state_d = SK_TOP;
      SK_TOP:    state_d = SK_IDLE;
      default:   state_d = SK_IDLE;
    endcase
  end

  always_comb begin
    count_d    = count_q;
    ptr_d      = ptr_q;
    op_d       = op_q;
    code_d     = code_q;
    ent_note_d = ent_note_q;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '{code: code_q, note: ent_note_q};
    raddr      = '0;
    rsp_o      = '{done: 1'b0, nonempty: 1'b0, note: ent_note_q};
    unique case (state_q)
      SK_IDLE: begin
        if (cmd_i.valid) begin
          op_d       = cmd_i.op;
          code_d     = cmd_i.code;
          ent_note_d = cmd_i.note;
          unique case (cmd_i.op)
            OP_PUSH: begin
              if (!full) begin
                we      = 1'b1;
                waddr   = AW'(count_q);
                wdata   = '{code: cmd_i.code, note: cmd_i.note};
                count_d = CW'(cnt_e + ONE_E);
                rsp_o   = '{done: 1'b1, nonempty: 1'b1, note: cmd_i.note};
              end else begin
                ptr_d = '0;
                raddr = AW'(ONE_E);
                if (!(ONE_E < cnt_e)) begin
                  count_d = CW'(cnt_e - ONE_E);
                end
              end
            end
            OP_RELEASE: begin
              if (count_q == '0) begin
                rsp_o.done = 1'b1;
              end else begin
                raddr = AW'(cnt_e - ONE_E);
                ptr_d = AW'(cnt_e - ONE_E);
              end
            end
            default: begin
              count_d    = '0;
              rsp_o.done = 1'b1;
            end
          endcase
        end
      end
      SK_SEARCH: begin
        if (match) begin
          if (hit_shift) begin
            raddr = AW'(ptr_e + ONE_E);
          end else begin
            count_d = CW'(cnt_e - ONE_E);
            if (cnt_e == ONE_E) begin
              rsp_o.done = 1'b1;
            end
          end
        end else if (!ptr_zero) begin
          raddr = AW'(ptr_e - ONE_E);
          ptr_d = AW'(ptr_e - ONE_E);
        end
      end
      SK_COMPACT: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = rd_q;
        if (cmp_more) begin
          raddr = AW'(ptr_e + TWO_E);
          ptr_d = AW'(ptr_e + ONE_E);
        end else begin
          count_d = CW'(cnt_e - ONE_E);
        end
      end
      SK_PUT: begin
        we      = 1'b1;
        waddr   = AW'(count_q);
        count_d = CW'(cnt_e + ONE_E);
        rsp_o   = '{done: 1'b1, nonempty: 1'b1, note: ent_note_q};
      end
      SK_TOP_RD: begin
        raddr = AW'(cnt_e - ONE_E);
      end
      SK_TOP: begin
        rsp_o = '{done: 1'b1, nonempty: 1'b1, note: rd_q.note};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SK_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      op_q    <= OP_PUSH;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      op_q    <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    ent_note_q <= ent_note_d;
  end

endmodule

FILE: hw/rtl/lnpks_checker.sv
`include "last_note_priority_key_stack_unit_assert.svh"

module lnpks_checker
  import lnpks_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  localparam logic [NOTE_W-1:0] NOTE_LIMIT = NOTE_W'(NOTE_MAX);

  logic       in_xfer;
  logic       out_xfer;
  logic       in_known;
  logic [1:0] outst_q, outst_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign in_known = !$isunknown({s_axis_tuser, s_axis_tdata});
  assign outst_d  = outst_q + 2'(in_xfer) - 2'(out_xfer);

  // Track transfers taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= 2'd0;
    end else begin
      outst_q <= outst_d;
    end
  end

  `LNPKS_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `LNPKS_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, !s_axis_tready)
  `LNPKS_IMPLIES(a_note_range, clk_i, rst_ni, m_axis_tvalid, (m_axis_tdata[13:0] <= NOTE_LIMIT) && !m_axis_tdata[15])
  `LNPKS_IMPLIES(a_no_orphan, clk_i, rst_ni, m_axis_tvalid, outst_q != 2'd0)
  `LNPKS_IMPLIES(a_outst_bound, clk_i, rst_ni, 1'b1, (outst_q != 2'd3) && in_known)

endmodule

bind last_note_priority_key_stack_unit lnpks_checker u_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import lnpks_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM = 1850;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 16;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam string ROW_LO = "zsxdcvgbhnjm,l.;/";
  localparam string ROW_HI = "q2w3er5t6y7ui9o0p[=]";

  typedef struct packed {
    logic [1:0]        req;
    logic [7:0]        code;
    logic [7:0]        ch;
    logic              typed;
    logic [NOTE_W-1:0] note;
    logic              gate;
  } key_event_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              gate;
  } tone_t;

  localparam int unsigned N_DIRECTED = 25;
  localparam key_event_t DIR_TBL [N_DIRECTED] = '{
    '{REQ_UNUSED,  8'hff, 8'hff,      1'b1, 14'd0,    1'b0},
    '{REQ_CLEAR,   8'h00, 8'h00,      1'b1, 14'd0,    1'b0},
    '{REQ_RELEASE, 8'h00, 8'h00,      1'b1, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h80, 8'h00,      1'b1, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h01, "z",        1'b1, 14'd2400, 1'b1},
    '{REQ_PRESS,   8'h10, CHAR_PLUS,  1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h10, CHAR_PLUS,  1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h10, CHAR_PLUS,  1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h10, CHAR_PLUS,  1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h02, "]",        1'b1, 14'd9100, 1'b1},
    '{REQ_PRESS,   8'hff, 8'hff,      1'b0, 14'd0,    1'b0},
    '{REQ_RELEASE, 8'h02, 8'h00,      1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h20, CHAR_MINUS, 1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h20, CHAR_MINUS, 1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h20, CHAR_MINUS, 1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h20, CHAR_MINUS, 1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h20, CHAR_MINUS, 1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h20, CHAR_MINUS, 1'b0, 14'd0,    1'b0},
    '{REQ_PRESS,   8'h00, "z",        1'b1, 14'd0,    1'b1},
    '{REQ_PRESS,   8'h00, "q",        1'b0, 14'd0,    1'b0},
    '{REQ_RELEASE, 8'haa, 8'h00,      1'b0, 14'd0,    1'b0},
    '{REQ_RELEASE, 8'h00, 8'h00,      1'b0, 14'd0,    1'b0},
    '{REQ_RELEASE, 8'h01, 8'h00,      1'b0, 14'd0,    1'b0},
    '{REQ_RELEASE, 8'h00, 8'h00,      1'b0, 14'd0,    1'b0},
    '{REQ_CLEAR,   8'h55, 8'haa,      1'b0, 14'd0,    1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int unsigned     src_idle_pct = 19;
  int unsigned     snk_idle_pct = 53;
  bit              rx_hold = 1'b0;
  int unsigned     err_cnt = 0;
  longint unsigned cycles = 0;

  logic [7:0]        held_code_m [DEPTH];
  logic [NOTE_W-1:0] held_note_m [DEPTH];
  int                held_n = 0;
  int                oct_m = int'(OCT_RESET);
  logic [NOTE_W-1:0] cur_note = '0;
  logic              cur_gate = 1'b0;
  tone_t             tone_q [$];

  last_note_priority_key_stack_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void stack_push(logic [7:0] code, int note);
    if (held_n >= int'(DEPTH)) begin
      for (int j = 0; j < int'(DEPTH) - 1; j++) begin
        held_code_m[j] = held_code_m[j+1];
        held_note_m[j] = held_note_m[j+1];
      end
      held_n = DEPTH - 1;
    end
    held_code_m[held_n] = code;
    held_note_m[held_n] = note[NOTE_W-1:0];
    held_n++;
    cur_note = note[NOTE_W-1:0];
    cur_gate = 1'b1;
  endfunction

  function automatic void settle_top();
    if (held_n > 0) cur_note = held_note_m[held_n-1];
    else cur_gate = 1'b0;
  endfunction

  function automatic tone_t advance_keyboard(key_event_t ev);
    int    hit;
    tone_t t;
    hit = -1;
    case (ev.req)
      REQ_PRESS: begin
        if (ev.ch == CHAR_PLUS && oct_m < int'(OCT_MAX)) begin
          oct_m++;
        end else if (ev.ch == CHAR_MINUS && oct_m > 0) begin
          oct_m--;
        end else begin
          for (int i = 0; i < ROW_LO.len(); i++)
            if (ev.ch == ROW_LO[i])
              stack_push(ev.code, (i + oct_m * SEMIS_PER_OCT) * CENTS_PER_SEMI);
          for (int i = 0; i < ROW_HI.len(); i++)
            if (ev.ch == ROW_HI[i])
              stack_push(ev.code, (i + (oct_m + 1) * SEMIS_PER_OCT) * CENTS_PER_SEMI);
        end
      end
      REQ_RELEASE: begin
        for (int i = held_n - 1; i >= 0; i--)
          if (hit < 0 && held_code_m[i] == ev.code) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j < held_n - 1; j++) begin
            held_code_m[j] = held_code_m[j+1];
            held_note_m[j] = held_note_m[j+1];
          end
          held_n--;
        end
        settle_top();
      end
      REQ_CLEAR: begin
        held_n = 0;
        settle_top();
      end
      default: begin
      end
    endcase
    t.note = cur_note;
    t.gate = cur_gate;
    return t;
  endfunction

  task automatic put_event(input key_event_t ev);
    tone_t t;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ev.ch, ev.code};
    s_axis_tuser  <= ev.req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    t = advance_keyboard(ev);
    if (ev.typed) begin
      t.note = ev.note;
      t.gate = ev.gate;
    end
    tone_q.push_back(t);
  endtask

  task automatic random_event(input int mode);
    key_event_t  ev;
    int unsigned r;
    ev = '0;
    r = $urandom_range(99);
    ev.code = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    if (mode == 2 && r < 50) begin
      ev.req  = 2'($urandom_range(3));
      ev.code = 8'($urandom_range(255));
      ev.ch   = 8'($urandom_range(255));
    end else if (r < (mode == 0 ? 70 : 25)) begin
      ev.req = REQ_PRESS;
      if ($urandom_range(1)) ev.ch = ROW_LO[$urandom_range(ROW_LO.len() - 1)];
      else ev.ch = ROW_HI[$urandom_range(ROW_HI.len() - 1)];
    end else if (r < (mode == 0 ? 78 : 33)) begin
      ev.req = REQ_PRESS;
      ev.ch  = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
    end else if (r < 93) begin
      ev.req = REQ_RELEASE;
      ev.ch  = 8'($urandom_range(255));
      if (held_n > 0 && $urandom_range(9) < 8)
        ev.code = held_code_m[$urandom_range(held_n - 1)];
    end else if (r < 96) begin
      ev.req = REQ_CLEAR;
      ev.ch  = 8'($urandom_range(255));
    end else begin
      ev.req = 2'($urandom_range(3));
      ev.ch  = 8'($urandom_range(255));
    end
    put_event(ev);
  endtask

  task automatic drain_tones();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tone_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk_i);
        rx_hold = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    tone_t t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tone_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected transfer: actual note %0d gate %0b", $time,
                 m_axis_tdata[NOTE_W-1:0], m_axis_tdata[NOTE_W]);
      end else begin
        t = tone_q.pop_front();
        if (m_axis_tdata[NOTE_W-1:0] !== t.note || m_axis_tdata[NOTE_W] !== t.gate ||
            m_axis_tdata[15] !== 1'b0) begin
          err_cnt++;
          $display("%0t mismatch: expected note %0d gate %0b pad 0, actual note %0d gate %0b pad %0b",
                   $time, t.note, t.gate, m_axis_tdata[NOTE_W-1:0], m_axis_tdata[NOTE_W],
                   m_axis_tdata[15]);
        end
      end
    end
  end

  initial begin
    int mode;
    int seg_left;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < int'(N_DIRECTED); i++) put_event(DIR_TBL[i]);
    drain_tones();
    mode = 0;
    seg_left = 0;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 53 : 0;
      snk_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 19 : 0;
      if (ph == 2) rx_hold = 1'b1;
      for (int n = 0; n < int'(N_RANDOM) / 3; n++) begin
        if (seg_left == 0) begin
          mode = $urandom_range(2);
          seg_left = $urandom_range(60, 20);
        end
        seg_left--;
        random_event(mode);
      end
      drain_tones();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
